[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the activity selector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define IAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define IAS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[design/ias_pkg.sv]
// ----------------------------------------------------------------------------
// ias_pkg
// Shared types and constants of the interval activity selector.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int DEF_MAX_ACTIVITIES = 32;
    localparam int MAX_RESULTS        = 32;
    localparam int RES_CNT_W          = $clog2(MAX_RESULTS + 1);
    localparam int DATA_W             = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // accept one item into the sorter
        logic scan;   // scan phase active
    } ias_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_end;  // sorter empty or result limit reached
    } ias_status_t;

endpackage

[design/ias_ctrl.sv]
// ----------------------------------------------------------------------------
// ias_ctrl
// Controller: load phase until the last item, then scan phase until done.
// ----------------------------------------------------------------------------
module ias_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 last_item,
    input  ias_pkg::ias_status_t status,
    output ias_pkg::ias_cmd_t    cmd,
    output logic                 busy
);
    import ias_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    // Decode commands
    assign cmd.load = start && !busy_reg;
    assign cmd.scan = (state_reg == ST_SCAN);
    assign busy     = busy_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (cmd.load && last_item)
                begin
                    state_next = ST_SCAN;
                    busy_next  = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_LOAD;
                    busy_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                busy_next  = 1'b0;
            end
        endcase
    end

    // Hold state and busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

[design/ias_datapath.sv]
// ----------------------------------------------------------------------------
// ias_datapath
// Systolic insertion sorter on end time, followed by a shifting greedy scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ias_datapath #(
    parameter int MAX_ACTIVITIES = ias_pkg::DEF_MAX_ACTIVITIES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ias_pkg::ias_cmd_t          cmd,
    output ias_pkg::ias_status_t       status,
    input  logic [ias_pkg::DATA_W-1:0] act_index,
    input  logic [ias_pkg::DATA_W-1:0] act_start,
    input  logic [ias_pkg::DATA_W-1:0] act_end,
    output logic                       result_valid,
    output logic [ias_pkg::DATA_W-1:0] chosen_index,
    output logic                       final_choice,
    output logic                       overflow
);
    import ias_pkg::*;

    localparam int CNT_W = $clog2(MAX_ACTIVITIES + 1);

    // Sorter cells, kept in ascending end order
    logic [DATA_W-1:0] cell_index_reg [MAX_ACTIVITIES];
    logic [DATA_W-1:0] cell_start_reg [MAX_ACTIVITIES];
    logic [DATA_W-1:0] cell_end_reg   [MAX_ACTIVITIES];

    logic [CNT_W-1:0]     count_reg,     count_next;
    logic                 dropped_reg,   dropped_next;
    logic [DATA_W-1:0]    last_end_reg,  last_end_next;
    logic [RES_CNT_W-1:0] sel_count_reg, sel_count_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [DATA_W-1:0]    pend_index_reg, pend_index_next;

    logic                 valid_reg, valid_next;
    logic [DATA_W-1:0]    index_reg, index_next;
    logic                 final_reg, final_next;
    logic                 ovf_reg,   ovf_next;

    logic [MAX_ACTIVITIES-1:0] later;
    logic full;
    logic scan_end;
    logic scan_step;
    logic head_sel;

    assign full      = (count_reg == CNT_W'(MAX_ACTIVITIES));
    assign scan_end  = (count_reg == '0) || (sel_count_reg == RES_CNT_W'(MAX_RESULTS));
    assign scan_step = cmd.scan && !scan_end;
    assign head_sel  = (cell_start_reg[0] >= last_end_reg);
    assign status.scan_end = scan_end;

    // Flag cells that must move up: empty, or ending strictly after the new item
    always_comb
    begin
        for (int i = 0; i < MAX_ACTIVITIES; i++)
        begin
            later[i] = (CNT_W'(i) >= count_reg) || (cell_end_reg[i] > act_end);
        end
    end

    // Insert on load, shift towards the head on scan
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            for (int i = 0; i < MAX_ACTIVITIES; i++)
            begin
                if (i > 0 && later[(i > 0) ? i - 1 : 0])
                begin
                    cell_index_reg[i] <= cell_index_reg[(i > 0) ? i - 1 : 0];
                    cell_start_reg[i] <= cell_start_reg[(i > 0) ? i - 1 : 0];
                    cell_end_reg[i]   <= cell_end_reg[(i > 0) ? i - 1 : 0];
                end
                else if (later[i])
                begin
                    cell_index_reg[i] <= act_index;
                    cell_start_reg[i] <= act_start;
                    cell_end_reg[i]   <= act_end;
                end
            end
        end
        else if (scan_step)
        begin
            for (int i = 0; i < MAX_ACTIVITIES - 1; i++)
            begin
                cell_index_reg[i] <= cell_index_reg[i + 1];
                cell_start_reg[i] <= cell_start_reg[i + 1];
                cell_end_reg[i]   <= cell_end_reg[i + 1];
            end
        end
    end

    // Control and result next values
    always_comb
    begin
        count_next      = count_reg;
        dropped_next    = dropped_reg;
        last_end_next   = last_end_reg;
        sel_count_next  = sel_count_reg;
        pend_valid_next = pend_valid_reg;
        pend_index_next = pend_index_reg;
        valid_next      = 1'b0;
        index_next      = index_reg;
        final_next      = final_reg;
        ovf_next        = ovf_reg;
        priority if (cmd.load)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (scan_step)
        begin
            // Examine the head cell, emit the previous choice once a new one is found
            count_next = count_reg - CNT_W'(1);
            if (head_sel)
            begin
                if (pend_valid_reg)
                begin
                    valid_next = 1'b1;
                    index_next = pend_index_reg;
                    final_next = 1'b0;
                    ovf_next   = dropped_reg;
                end
                pend_valid_next = 1'b1;
                pend_index_next = cell_index_reg[0];
                last_end_next   = cell_end_reg[0];
                sel_count_next  = sel_count_reg + RES_CNT_W'(1);
            end
        end
        else if (cmd.scan)
        begin
            // Flush the held choice as final and clear for the next set
            valid_next      = pend_valid_reg;
            index_next      = pend_index_reg;
            final_next      = 1'b1;
            ovf_next        = dropped_reg;
            pend_valid_next = 1'b0;
            count_next      = '0;
            dropped_next    = 1'b0;
            last_end_next   = '0;
            sel_count_next  = '0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            last_end_reg   <= '0;
            sel_count_reg  <= '0;
            pend_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
            last_end_reg   <= last_end_next;
            sel_count_reg  <= sel_count_next;
            pend_valid_reg <= pend_valid_next;
            valid_reg      <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        pend_index_reg <= pend_index_next;
        index_reg      <= index_next;
        final_reg      <= final_next;
        ovf_reg        <= ovf_next;
    end

    assign result_valid = valid_reg;
    assign chosen_index = index_reg;
    assign final_choice = final_reg;
    assign overflow     = ovf_reg;

    `IAS_NEVER(a_load_in_scan, cmd.load && cmd.scan, "item loaded during scan")
    `IAS_NEVER(a_count_range, count_reg > CNT_W'(MAX_ACTIVITIES), "held count out of range")
    `IAS_ASSERT(a_final_ends, (valid_reg && final_reg) |=> !valid_reg, "result after final")
    `IAS_ASSERT(a_flush_pending, (cmd.scan && scan_end) |-> pend_valid_reg,
        "set closed with no choice")

endmodule

[design/interval_activity_selector.sv]
// ----------------------------------------------------------------------------
// interval_activity_selector
// Greedy earliest-finish activity selection over a stably sorted set.
// ----------------------------------------------------------------------------
//  channel  | handshake               | fields
//  ---------+-------------------------+------------------------------------------
//  item in  | start, busy             | act_index, act_start, act_end, last_item
//  result   | result_valid (strobe)   | chosen_index, final_choice, overflow
//
//  Loading takes one item per cycle while busy is low; the sorter cells absorb
//  each on arrival. After the last item, busy stays high while the cells shift
//  past the compare stage, until the sorter is empty or the result limit is hit.
//  Each result strobes in the cycle after its successor is found; the final one
//  strobes in the same cycle that busy falls.
//  Reset clears the held count, flags and controller; cell contents are kept.
//  Results are strobed for one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module interval_activity_selector #(
    parameter int MAX_ACTIVITIES = ias_pkg::DEF_MAX_ACTIVITIES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ias_pkg::DATA_W-1:0] act_index,
    input  logic [ias_pkg::DATA_W-1:0] act_start,
    input  logic [ias_pkg::DATA_W-1:0] act_end,
    input  logic                       last_item,
    output logic                       result_valid,
    output logic [ias_pkg::DATA_W-1:0] chosen_index,
    output logic                       final_choice,
    output logic                       overflow
);
    import ias_pkg::*;

    ias_cmd_t    cmd;
    ias_status_t status;

    // Sequence the load and scan phases
    ias_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (last_item),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Sort and select
    ias_datapath #(
        .MAX_ACTIVITIES (MAX_ACTIVITIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .act_index    (act_index),
        .act_start    (act_start),
        .act_end      (act_end),
        .result_valid (result_valid),
        .chosen_index (chosen_index),
        .final_choice (final_choice),
        .overflow     (overflow)
    );

endmodule

[verif/tb_interval_activity_selector.sv]
// ----------------------------------------------------------------------------
// tb_interval_activity_selector
// Self-checking bench for the earliest-finish activity selector.
// Sets of activities are loaded through the start/busy handshake: first a few
// hand-built sets (field extremes, equal end times, starts after ends, zero
// length chains), then random sets: an overfull store, a full one, then sets of
// mostly small size with random idle bursts. A ledger keeps its own stable sorted
// copy of each set and predicts every strobed choice, checked field by field.
// ----------------------------------------------------------------------------
module tb_interval_activity_selector;

    localparam int HELD_MAX    = ias_pkg::DEF_MAX_ACTIVITIES;
    localparam int PICK_MAX    = ias_pkg::MAX_RESULTS;
    localparam int W           = ias_pkg::DATA_W;
    localparam int ITEM_TARGET = 300;
    localparam int CALM_FROM   = 240;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [W-1:0] index;
        logic         last_pick;
        logic         spill;
    } choice_t;

    // Predict the chosen activities of each set and check the strobed ones
    class selection_ledger;
        logic [W-1:0] held_idx [HELD_MAX];
        logic [W-1:0] held_start [HELD_MAX];
        logic [W-1:0] held_end [HELD_MAX];
        int unsigned  held_num;
        bit           spilled;
        choice_t      pending_choices[$];
        int unsigned  mismatches;

        function new();
            held_num   = 0;
            spilled    = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return pending_choices.size();
        endfunction

        // Insert an accepted item stably; on the closing item run the greedy scan
        function void note_activity(logic [W-1:0] idx, logic [W-1:0] st,
                                    logic [W-1:0] en, logic closes);
            int unsigned  pos;
            int unsigned  emitted;
            logic [W-1:0] free_from;
            choice_t      pick;
            if (held_num >= HELD_MAX)
            begin
                spilled = 1;
            end
            else
            begin
                pos = held_num;
                while (pos > 0 && held_end[pos-1] > en)
                begin
                    held_idx[pos]   = held_idx[pos-1];
                    held_start[pos] = held_start[pos-1];
                    held_end[pos]   = held_end[pos-1];
                    pos--;
                end
                held_idx[pos]   = idx;
                held_start[pos] = st;
                held_end[pos]   = en;
                held_num++;
            end
            if (!closes)
                return;
            free_from = '0;
            emitted   = 0;
            for (int i = 0; i < held_num && emitted < PICK_MAX; i++)
            begin
                if (held_start[i] >= free_from)
                begin
                    pick.index      = held_idx[i];
                    pick.last_pick  = 1'b0;
                    pick.spill      = spilled;
                    pending_choices = {pending_choices, pick};
                    free_from = held_end[i];
                    emitted++;
                end
            end
            if (emitted > 0)
                pending_choices[pending_choices.size()-1].last_pick = 1'b1;
            held_num = 0;
            spilled  = 0;
        endfunction

        // Compare one strobed choice with the oldest prediction
        function void check_choice(logic [W-1:0] idx, logic fin, logic ovf);
            choice_t want;
            if (pending_choices.size() == 0)
            begin
                $error("unexpected choice: chosen_index=%0h final_choice=%0b overflow=%0b",
                       idx, fin, ovf);
                mismatches++;
                return;
            end
            want = pending_choices.pop_front();
            if (idx !== want.index)
            begin
                $error("chosen_index: expected %0h, actual %0h", want.index, idx);
                mismatches++;
            end
            if (fin !== want.last_pick)
            begin
                $error("final_choice: expected %0b, actual %0b", want.last_pick, fin);
                mismatches++;
            end
            if (ovf !== want.spill)
            begin
                $error("overflow: expected %0b, actual %0b", want.spill, ovf);
                mismatches++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic [W-1:0] act_index;
    logic [W-1:0] act_start;
    logic [W-1:0] act_end;
    logic         last_item;
    logic         result_valid;
    logic [W-1:0] chosen_index;
    logic         final_choice;
    logic         overflow;

    selection_ledger ledger;
    int unsigned     items_sent;
    int unsigned     stall_cycles;

    interval_activity_selector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .act_index    (act_index),
        .act_start    (act_start),
        .act_end      (act_end),
        .last_item    (last_item),
        .result_valid (result_valid),
        .chosen_index (chosen_index),
        .final_choice (final_choice),
        .overflow     (overflow)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Check every strobed choice
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            ledger.check_choice(chosen_index, final_choice, overflow);
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy && rst_n) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one item and hold it until accepted
    task automatic send_activity(logic [W-1:0] idx, logic [W-1:0] st,
                                 logic [W-1:0] en, logic closes);
        @(negedge clk);
        start     = 1'b1;
        act_index = idx;
        act_start = st;
        act_end   = en;
        last_item = closes;
        do @(posedge clk); while (busy);
        ledger.note_activity(idx, st, en, closes);
        items_sent++;
    endtask

    // Drop start for a number of cycles
    task automatic hold_off(int unsigned cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Load one random set; narrow sets crowd their times to force overlaps
    task automatic send_random_set(int unsigned count, bit with_gaps);
        bit           narrow;
        logic [W-1:0] st;
        logic [W-1:0] en;
        narrow = ($urandom_range(0, 2) != 0);
        for (int unsigned k = 0; k < count; k++)
        begin
            if (with_gaps && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 18));
            if (narrow)
            begin
                st = W'($urandom_range(0, 60));
                if ($urandom_range(0, 7) == 0)
                    en = W'($urandom_range(0, 60));
                else
                    en = st + W'($urandom_range(0, 12));
            end
            else
            begin
                st = W'($urandom_range(0, 65535));
                en = W'($urandom_range(0, 65535));
            end
            send_activity(W'($urandom_range(0, 65535)), st, en, k == count - 1);
        end
    endtask

    // Main sequence
    initial
    begin
        int unsigned set_no;
        int unsigned count;
        int unsigned roll;
        ledger       = new();
        items_sent   = 0;
        stall_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        act_index    = '0;
        act_start    = '0;
        act_end      = '0;
        last_item    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Single activities at the field extremes
        send_activity(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
        send_activity(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
        send_activity(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
        // Equal end times keep arrival order
        send_activity(16'h0001, 16'd0, 16'd10, 1'b0);
        send_activity(16'h0002, 16'd0, 16'd10, 1'b0);
        send_activity(16'h0003, 16'd10, 16'd10, 1'b0);
        send_activity(16'h0004, 16'd5, 16'd10, 1'b1);
        // Start after end, and ends arriving out of order
        send_activity(16'h5555, 16'd9, 16'd3, 1'b0);
        send_activity(16'h0006, 16'd0, 16'd1, 1'b0);
        send_activity(16'h0007, 16'd1, 16'd2, 1'b0);
        send_activity(16'h0008, 16'd2, 16'hFFFF, 1'b1);
        // Zero length activities all chain at time zero
        send_activity(16'h0009, 16'd0, 16'd0, 1'b0);
        send_activity(16'h000A, 16'd0, 16'd0, 1'b0);
        send_activity(16'h000B, 16'd0, 16'd0, 1'b1);

        // Random sets: an overfull store, a full one, then mostly small sets
        set_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (set_no == 0)
                count = HELD_MAX + 1;
            else if (set_no == 1)
                count = HELD_MAX;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 78)
                    count = $urandom_range(1, 8);
                else if (roll < 95)
                    count = $urandom_range(9, HELD_MAX);
                else
                    count = $urandom_range(HELD_MAX + 1, HELD_MAX + 8);
            end
            // Let the block drain completely once before carrying on
            if (set_no == 6)
            begin
                @(negedge clk);
                start = 1'b0;
                while (ledger.pending() != 0)
                    @(posedge clk);
            end
            send_random_set(count, items_sent < CALM_FROM);
            set_no++;
        end

        // Drain and settle
        @(negedge clk);
        start = 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (HELD_MAX + 8) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
